[rtl/sba_pkg.sv]
// Package for the sprite blitter: constants, types and the pixel blend function.
`default_nettype none
package sba_pkg;
	localparam int TexDepth = 4096;
	localparam int FbDepth = 65536;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_BLIT  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_WRITE = 2'd3;

	localparam logic [2:0] REG_TEX_STRIDE  = 3'd0;
	localparam logic [2:0] REG_CROP_WIDTH  = 3'd1;
	localparam logic [2:0] REG_CROP_HEIGHT = 3'd2;
	localparam logic [2:0] REG_SRC_OFF_X   = 3'd3;
	localparam logic [2:0] REG_SRC_OFF_Y   = 3'd4;
	localparam logic [2:0] REG_FB_WIDTH    = 3'd5;
	localparam logic [2:0] REG_FB_HEIGHT   = 3'd6;
	localparam logic [2:0] REG_BLEND_MODE  = 3'd7;

	localparam logic [7:0] ALPHA_MIN = 8'h10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_SETUP,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// floor(v / 255) for v < 2**14 (max 63*255 = 16065)
	function automatic logic [5:0] div255(input logic [13:0] v);
		logic [14:0] t;
		logic [22:0] p;
		begin
			t = {1'b0, v} + 15'd1;
			p = {8'd0, t} + {t, 8'd0};
			div255 = p[21:16];
		end
	endfunction

	function automatic logic [15:0] mix565(input logic [15:0] s, input logic [15:0] d,
			input logic [7:0] a);
		logic [7:0] na;
		logic [13:0] r, g, b;
		logic [5:0] rq, gq, bq;
		begin
			na = 8'd255 - a;
			r = 14'(s[15:11]) * 14'(a) + 14'(d[15:11]) * 14'(na);
			g = 14'(s[10:5]) * 14'(a) + 14'(d[10:5]) * 14'(na);
			b = 14'(s[4:0]) * 14'(a) + 14'(d[4:0]) * 14'(na);
			rq = div255(r);
			gq = div255(g);
			bq = div255(b);
			mix565 = {rq[4:0], gq, bq[4:0]};
		end
	endfunction
endpackage
`default_nettype wire

[rtl/sprite_blit_alpha_rgb565_top.sv]
// Sprite blitter top level: command decode, clip setup, pixel walker and both stores.
// Load and write pass through ACCESS to DONE, read through ACCESS and DRAIN; a rejected or
// empty blit goes from SETUP straight to DONE. A clipped blit walks its rows in WALK with
// a row setup step before each row, one texel and framebuffer read a cycle, write-back the next cycle.
// One command is in flight at a time; a new one is taken after its result beat leaves.
// arst_n resets control state and config registers; both stores are undefined until written.
`default_nettype none
module sprite_blit_alpha_rgb565_top
	import sba_pkg::*;
#(
	parameter int TEX_DEPTH = sba_pkg::TexDepth,
	parameter int FB_DEPTH = sba_pkg::FbDepth
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// command[1:0], address[17:2], pixel[33:18], alpha[41:34], pos_x[53:42], pos_y[65:54],
	// mirror[66], zero fill to 72
	input  wire [71:0]  s_axis_tdata,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// read_data[15:0], pixels_written[32:16], off_screen[33], zero fill to 40
	output logic [39:0] m_axis_tdata,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire [2:0]   cfg_index,
	input  wire [12:0]  cfg_data
);
	localparam int TA = $clog2(TEX_DEPTH);
	localparam int FA = $clog2(FB_DEPTH);

	state_t state_q, state_d;

	logic [12:0] tex_stride_q, crop_width_q, crop_height_q;
	logic [11:0] src_off_x_q, src_off_y_q;
	logic [8:0]  fb_width_q, fb_height_q;
	logic        blend_mode_q;

	logic [1:0]  cmd_q;
	logic [15:0] addr_q, pix_q;
	logic [7:0]  alpha_q;
	logic signed [11:0] pos_x_q, pos_y_q;
	logic        mir_q;

	logic [15:0] rd_q;
	logic [16:0] count_q;
	logic        off_q;

	// clip results
	logic signed [15:0] ex_q, ey_q, ixo_q, iyo_q, ox_q, oy_q;
	logic signed [15:0] ix_q, iy_q;
	logic signed [31:0] srow_q;   // (iy+iyo)*stride
	logic [17:0] drow_q;          // (iy+oy)*fbw
	logic        row_ok_q;

	// pixel pipeline
	logic        v_s1;
	logic        ok_s1;
	logic [FA-1:0] di_s1;

	logic tex_we, fb_we;
	logic [TA-1:0] tex_waddr, tex_raddr;
	logic [FA-1:0] fb_waddr, fb_raddr;
	logic [23:0] tex_wdata, tex_rdata;
	logic [15:0] fb_wdata, fb_rdata;

	sba_ram #(.Width(24), .Depth(TEX_DEPTH)) u_tex (
		.clk, .we(tex_we), .waddr(tex_waddr), .wdata(tex_wdata),
		.raddr(tex_raddr), .rdata(tex_rdata)
	);
	sba_ram #(.Width(16), .Depth(FB_DEPTH)) u_fb (
		.clk, .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
		.raddr(fb_raddr), .rdata(fb_rdata)
	);

	assign cfg_ready = (state_q == ST_IDLE);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_DONE);
	assign m_axis_tdata = {6'd0, off_q, count_q, rd_q};

	logic in_acc;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_stride_q <= 13'd64;
			crop_width_q <= 13'd16;
			crop_height_q <= 13'd16;
			src_off_x_q <= '0;
			src_off_y_q <= '0;
			fb_width_q <= 9'd128;
			fb_height_q <= 9'd128;
			blend_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TEX_STRIDE:  tex_stride_q <= cfg_data;
				REG_CROP_WIDTH:  crop_width_q <= cfg_data;
				REG_CROP_HEIGHT: crop_height_q <= cfg_data;
				REG_SRC_OFF_X:   src_off_x_q <= cfg_data[11:0];
				REG_SRC_OFF_Y:   src_off_y_q <= cfg_data[11:0];
				REG_FB_WIDTH:    fb_width_q <= cfg_data[8:0];
				REG_FB_HEIGHT:   fb_height_q <= cfg_data[8:0];
				REG_BLEND_MODE:  blend_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// blit geometry from the setup state (registered into ex/ey/... at setup)
	logic signed [15:0] fbw_s, fbh_s, cw_s, ch_s, px_s, py_s;
	logic signed [15:0] c_ex, c_ey, c_ixo, c_iyo, c_ox, c_oy;
	logic c_off;
	always_comb begin
		fbw_s = 16'(fb_width_q);
		fbh_s = 16'(fb_height_q);
		cw_s = 16'(crop_width_q);
		ch_s = 16'(crop_height_q);
		px_s = 16'(pos_x_q);
		py_s = 16'(pos_y_q);
		c_off = (px_s >= fbw_s) || (px_s + cw_s < 0) || (py_s >= fbh_s) || (py_s + ch_s < 0);
		c_ex = cw_s;
		c_ey = ch_s;
		c_ixo = 16'(src_off_x_q);
		c_iyo = 16'(src_off_y_q);
		c_ox = px_s;
		c_oy = py_s;
		if (c_ox < 0) begin
			c_ex = c_ex + c_ox;
			c_ixo = mir_q ? c_ixo + c_ox : c_ixo - c_ox;
			c_ox = '0;
		end
		if (c_oy < 0) begin
			c_ey = c_ey + c_oy;
			c_iyo = c_iyo - c_oy;
			c_oy = '0;
		end
		if (c_ox + c_ex > fbw_s) c_ex = fbw_s - c_ox;
		if (c_oy + c_ey > fbh_s) c_ey = fbh_s - c_oy;
		if (mir_q) c_ixo = c_ixo + cw_s - 16'sd1;
	end

	// walker address of current pixel
	logic signed [31:0] si;
	logic [17:0] di;
	logic issue, pix_ok, last_col, last_row;
	always_comb begin
		si = srow_q + 32'(ixo_q) + (mir_q ? -32'(ix_q) : 32'(ix_q));
		di = drow_q + 18'(ix_q) + 18'(ox_q);
		pix_ok = (si >= 0) && (si < TEX_DEPTH) && (32'(di) < FB_DEPTH);
		issue = (state_q == ST_WALK) && row_ok_q;
		last_col = (ix_q == ex_q - 16'sd1);
		last_row = (iy_q == ey_q - 16'sd1);
	end

	// Result pixel in stage 1, written back the cycle after its read. Pixels issued
	// back to back lie in one row and never share an entry, and a row change leaves a
	// gap for the row setup, so every read sees the previous write-back without forwarding.
	logic [15:0] newpix;
	logic do_wr;
	always_comb begin
		newpix = blend_mode_q ? mix565(tex_rdata[15:0], fb_rdata, tex_rdata[23:16])
			: tex_rdata[15:0];
		do_wr = v_s1 && ok_s1 && (!blend_mode_q || tex_rdata[23:16] >= ALPHA_MIN);
	end

	// memory ports
	always_comb begin
		tex_we = 1'b0;
		tex_waddr = addr_q[TA-1:0];
		tex_wdata = {alpha_q, pix_q};
		fb_we = 1'b0;
		fb_waddr = di_s1;
		fb_wdata = newpix;
		tex_raddr = si[TA-1:0];
		fb_raddr = di[FA-1:0];
		if (state_q == ST_ACCESS) begin
			fb_raddr = FA'(addr_q);
			if (cmd_q == CMD_LOAD && 32'(addr_q) < TEX_DEPTH) tex_we = 1'b1;
			if (cmd_q == CMD_WRITE && 32'(addr_q) < FB_DEPTH) begin
				fb_we = 1'b1;
				fb_waddr = FA'(addr_q);
				fb_wdata = pix_q;
			end
		end else if (do_wr) begin
			fb_we = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_acc) state_d = (s_axis_tdata[1:0] == CMD_BLIT) ? ST_SETUP
				: ST_ACCESS;
			ST_ACCESS: state_d = (cmd_q == CMD_READ) ? ST_DRAIN : ST_DONE;
			ST_SETUP:  state_d = (c_off || c_ex <= 0 || c_ey <= 0) ? ST_DONE : ST_WALK;
			ST_WALK:   if (row_ok_q && last_col && last_row) state_d = ST_DRAIN;
			ST_DRAIN:  if (!v_s1) state_d = ST_DONE;
			ST_DONE:   if (m_axis_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_s1 <= 1'b0;
			row_ok_q <= 1'b0;
			rd_q <= '0;
			count_q <= '0;
			off_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1 <= issue;
			if (in_acc) begin
				rd_q <= '0;
				count_q <= '0;
				off_q <= 1'b0;
			end
			if (state_q == ST_DRAIN && cmd_q == CMD_READ && !v_s1) begin
				rd_q <= (32'(addr_q) < FB_DEPTH) ? fb_rdata : 16'd0;
			end
			if (state_q == ST_SETUP) begin
				off_q <= c_off;
				row_ok_q <= 1'b0;
			end
			if (do_wr && count_q != 17'h1FFFF) count_q <= count_q + 17'd1;
			// row address products are registered while the walker holds
			if (state_q == ST_WALK) begin
				if (!row_ok_q) begin
					row_ok_q <= 1'b1;
				end else if (last_col) begin
					row_ok_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		di_s1 <= di[FA-1:0];
		ok_s1 <= pix_ok;
		if (in_acc) begin
			cmd_q <= s_axis_tdata[1:0];
			addr_q <= s_axis_tdata[17:2];
			pix_q <= s_axis_tdata[33:18];
			alpha_q <= s_axis_tdata[41:34];
			pos_x_q <= s_axis_tdata[53:42];
			pos_y_q <= s_axis_tdata[65:54];
			mir_q <= s_axis_tdata[66];
		end
		if (state_q == ST_SETUP) begin
			ex_q <= c_ex;
			ey_q <= c_ey;
			ixo_q <= c_ixo;
			iyo_q <= c_iyo;
			ox_q <= c_ox;
			oy_q <= c_oy;
			ix_q <= '0;
			iy_q <= '0;
		end
		if (state_q == ST_WALK) begin
			if (!row_ok_q) begin
				srow_q <= 32'(iy_q + iyo_q) * 32'(tex_stride_q);
				drow_q <= 18'(18'(iy_q + oy_q) * 18'(fb_width_q));
			end else if (last_col) begin
				ix_q <= '0;
				iy_q <= iy_q + 16'sd1;
			end else begin
				ix_q <= ix_q + 16'sd1;
			end
		end
	end
endmodule
`default_nettype wire

[rtl/sba_ram.sv]
// Generic single-port write, single-port read RAM with registered read data.
`default_nettype none
module sba_ram #(
	parameter int Width = 16,
	parameter int Depth = 256
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(Depth)-1:0]  waddr,
	input  wire [Width-1:0]          wdata,
	input  wire [$clog2(Depth)-1:0]  raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the sprite blitter: directed and random commands, scoreboard.
module tb;
	import sba_pkg::*;

	localparam int WatchdogLimit = 200000;

	typedef struct packed {
		logic        off_screen;
		logic [16:0] pixels_written;
		logic [15:0] read_data;
	} blit_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [12:0] cfg_data = '0;

	sprite_blit_alpha_rgb565_top dut (.*);

	// shadow copy of the block's registers and stores
	int unsigned tex_stride, crop_width, crop_height, src_off_x, src_off_y;
	int unsigned fb_width, fb_height, blend_mode;
	logic [23:0] tex_mem [TexDepth];
	logic [15:0] fb_mem [FbDepth];
	bit          tex_valid [TexDepth];
	bit          fb_valid [FbDepth];
	int          fb_written_list [$];

	blit_result_t expected_results [$];
	int errors = 0;
	int n_beats = 0, n_blits = 0, n_rejects = 0, n_reads = 0, n_pixels = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	bit in_reset_window = 1'b1;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] blend565(logic [15:0] s, logic [15:0] d, int unsigned a);
		int unsigned r, g, b;
		begin
			r = (s[15:11] * a + d[15:11] * (255 - a)) / 255;
			g = (s[10:5] * a + d[10:5] * (255 - a)) / 255;
			b = (s[4:0] * a + d[4:0] * (255 - a)) / 255;
			return {r[4:0], g[5:0], b[4:0]};
		end
	endfunction

	// Walk the clipped sprite. With commit clear only check that every touched entry
	// has been written; with commit set update the framebuffer shadow.
	function automatic int blit_walk(int x, int y, bit mir, bit commit,
			output bit clean, output bit off);
		longint fbw, fbh, cw, ch, ox, oy, ixo, iyo, ex, ey, m, si, di;
		int cnt;
		logic [23:0] t;
		begin
			fbw = fb_width; fbh = fb_height; cw = crop_width; ch = crop_height;
			ox = x; oy = y; ixo = src_off_x; iyo = src_off_y; ex = cw; ey = ch; m = 1;
			cnt = 0; clean = 1'b1; off = 1'b0;
			if (x >= fbw || x + cw < 0 || y >= fbh || y + ch < 0) begin
				off = 1'b1;
				return 0;
			end
			if (ox < 0) begin
				ex += ox;
				if (mir) ixo += ox; else ixo -= ox;
				ox = 0;
			end
			if (oy < 0) begin
				ey += oy;
				iyo -= oy;
				oy = 0;
			end
			if (ox + ex > fbw) ex = fbw - ox;
			if (oy + ey > fbh) ey = fbh - oy;
			if (mir) begin
				m = -1;
				ixo += cw - 1;
			end
			for (longint iy = 0; iy < ey; iy++) begin
				for (longint ix = 0; ix < ex; ix++) begin
					si = (iy + iyo) * tex_stride + ixo + ix * m;
					di = (iy + oy) * fbw + ix + ox;
					if (si < 0 || si >= TexDepth || di >= FbDepth) continue;
					if (!tex_valid[si] || !fb_valid[di]) clean = 1'b0;
					if (!commit) continue;
					t = tex_mem[si];
					if (blend_mode != 0) begin
						if (t[23:16] < ALPHA_MIN) continue;
						fb_mem[di] = blend565(t[15:0], fb_mem[di], t[23:16]);
					end else begin
						fb_mem[di] = t[15:0];
					end
					cnt++;
				end
			end
			return cnt;
		end
	endfunction

	function automatic blit_result_t predict_command(logic [1:0] cmd, logic [15:0] addr,
			logic [15:0] pix, logic [7:0] alpha, logic [11:0] px, logic [11:0] py, bit mir);
		blit_result_t r;
		bit clean, off;
		begin
			r = '0;
			case (cmd)
				CMD_LOAD: begin
					if (addr < TexDepth) begin
						tex_mem[addr] = {alpha, pix};
						tex_valid[addr] = 1'b1;
					end
				end
				CMD_BLIT: begin
					r.pixels_written = 17'(blit_walk($signed(px), $signed(py), mir, 1'b1,
						clean, off));
					r.off_screen = off;
				end
				CMD_READ: r.read_data = fb_mem[addr];
				default: begin
					fb_mem[addr] = pix;
					if (!fb_valid[addr]) fb_written_list = {fb_written_list, int'(addr)};
					fb_valid[addr] = 1'b1;
				end
			endcase
			return r;
		end
	endfunction

	// Sender: bursts of random length, random gaps between them.
	task automatic send_command(logic [1:0] cmd, logic [15:0] addr, logic [15:0] pix,
			logic [7:0] alpha, logic [11:0] px, logic [11:0] py, bit mir);
		int gap;
		begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					s_axis_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= {5'd0, mir, py, px, alpha, pix, addr, cmd};
			do @(posedge clk); while (!s_axis_tready);
			expected_results = {expected_results,
				predict_command(cmd, addr, pix, alpha, px, py, mir)};
			n_beats++;
			if (cmd == CMD_BLIT) n_blits++;
			if (cmd == CMD_READ) n_reads++;
		end
	endtask

	task automatic drain;
		begin
			s_axis_tvalid <= 1'b0;
			burst_left = 0;
			while (expected_results.size() != 0) @(posedge clk);
			repeat (8) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [2:0] idx, int unsigned value);
		begin
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= 13'(value);
			do @(posedge clk); while (!cfg_ready);
			cfg_valid <= 1'b0;
			case (idx)
				REG_TEX_STRIDE:  tex_stride = value;
				REG_CROP_WIDTH:  crop_width = value;
				REG_CROP_HEIGHT: crop_height = value;
				REG_SRC_OFF_X:   src_off_x = value;
				REG_SRC_OFF_Y:   src_off_y = value;
				REG_FB_WIDTH:    fb_width = value;
				REG_FB_HEIGHT:   fb_height = value;
				default:         blend_mode = value;
			endcase
		end
	endtask

	task automatic set_geometry(int unsigned stride, int unsigned cw, int unsigned ch,
			int unsigned sx, int unsigned sy, int unsigned fw, int unsigned fh, int unsigned bm);
		begin
			drain();
			write_reg(REG_TEX_STRIDE, stride);
			write_reg(REG_CROP_WIDTH, cw);
			write_reg(REG_CROP_HEIGHT, ch);
			write_reg(REG_SRC_OFF_X, sx);
			write_reg(REG_SRC_OFF_Y, sy);
			write_reg(REG_FB_WIDTH, fw);
			write_reg(REG_FB_HEIGHT, fh);
			write_reg(REG_BLEND_MODE, bm);
		end
	endtask

	// Issue a blit only when it touches written entries; otherwise read back a pixel.
	task automatic safe_blit(int x, int y, bit mir);
		bit clean, off;
		int cnt;
		begin
			cnt = blit_walk(x, y, mir, 1'b0, clean, off);
			if (clean)
				send_command(CMD_BLIT, 16'($urandom), 16'($urandom), 8'($urandom),
					12'(x), 12'(y), mir);
			else
				send_command(CMD_READ, 16'(fb_written_list[$urandom_range(0,
					fb_written_list.size() - 1)]), '0, '0, '0, '0, 1'b0);
		end
	endtask

	task automatic test_access_at_reset;
		begin
			send_command(CMD_LOAD, 16'd0, 16'hFFFF, 8'hFF, '0, '0, 1'b0);
			send_command(CMD_LOAD, 16'hFFFF, 16'h1234, 8'h55, '0, '0, 1'b0);
			send_command(CMD_WRITE, 16'hFFFF, 16'hFFFF, '0, '0, '0, 1'b0);
			send_command(CMD_WRITE, 16'd0, 16'h0000, '0, '0, '0, 1'b0);
			send_command(CMD_READ, 16'hFFFF, '0, '0, '0, '0, 1'b0);
			send_command(CMD_READ, 16'd0, '0, '0, '0, '0, 1'b0);
			// rejected on each side under the reset geometry
			send_command(CMD_BLIT, '0, '0, '0, 12'd128, 12'd0, 1'b0);
			send_command(CMD_BLIT, '0, '0, '0, -12'sd17, 12'd0, 1'b1);
			send_command(CMD_BLIT, '0, '0, '0, 12'd0, 12'h7FF, 1'b0);
			send_command(CMD_BLIT, '0, '0, '0, 12'd0, 12'h800, 1'b0);
		end
	endtask

	task automatic test_fill_stores;
		begin
			set_geometry(8, 4, 3, 1, 1, 8, 4, 0);
			for (int i = 0; i < 32; i++) begin
				send_command(CMD_LOAD, 16'(i), 16'($urandom), 8'($urandom), '0, '0, 1'b0);
				send_command(CMD_WRITE, 16'(i), 16'($urandom), '0, '0, '0, 1'b0);
			end
		end
	endtask

	task automatic test_opaque_clipping;
		begin
			safe_blit(0, 0, 1'b0);
			safe_blit(3, 1, 1'b1);
			safe_blit(-3, 2, 1'b0);
			safe_blit(-3, 2, 1'b1);
			safe_blit(5, -2, 1'b0);
			safe_blit(6, 2, 1'b1);
			safe_blit(-4, 0, 1'b0);
			safe_blit(-5, 0, 1'b0);
			safe_blit(8, 0, 1'b0);
			safe_blit(0, -4, 1'b0);
			// mirrored sprite cut at the left edge
			set_geometry(8, 4, 3, 0, 0, 8, 4, 0);
			safe_blit(-2, 1, 1'b1);
			send_command(CMD_READ, 16'd9, '0, '0, '0, '0, 1'b0);
		end
	endtask

	task automatic test_blend_threshold;
		begin
			set_geometry(8, 4, 2, 0, 0, 8, 4, 1);
			send_command(CMD_LOAD, 16'd0, 16'hFFFF, 8'd0, '0, '0, 1'b0);
			send_command(CMD_LOAD, 16'd1, 16'hF800, 8'd15, '0, '0, 1'b0);
			send_command(CMD_LOAD, 16'd2, 16'h07E0, 8'd16, '0, '0, 1'b0);
			send_command(CMD_LOAD, 16'd3, 16'h001F, 8'd255, '0, '0, 1'b0);
			send_command(CMD_LOAD, 16'd8, 16'h0000, 8'd128, '0, '0, 1'b0);
			send_command(CMD_LOAD, 16'd9, 16'hFFFF, 8'd200, '0, '0, 1'b0);
			safe_blit(1, 1, 1'b0);
			safe_blit(1, 1, 1'b1);
			for (int i = 9; i < 13; i++)
				send_command(CMD_READ, 16'(i), '0, '0, '0, '0, 1'b0);
		end
	endtask

	task automatic test_register_extremes;
		begin
			set_geometry(4096, 4096, 4096, 4095, 4095, 256, 256, 1);
			send_command(CMD_BLIT, '0, '0, '0, 12'd0, 12'h7FF, 1'b1);
			send_command(CMD_BLIT, '0, '0, '0, 12'h7FF, 12'd0, 1'b0);
			set_geometry(1, 0, 0, 0, 0, 1, 1, 0);
			safe_blit(0, 0, 1'b0);
			safe_blit(0, 0, 1'b1);
			send_command(CMD_BLIT, '0, '0, '0, 12'd1, 12'd0, 1'b0);
			send_command(CMD_BLIT, '0, '0, '0, -12'sd1, 12'd0, 1'b0);
			send_command(CMD_BLIT, '0, '0, '0, 12'd0, -12'sd1, 1'b0);
		end
	endtask

	task automatic test_random_mix;
		int r;
		begin
			for (int phase = 0; phase < 4; phase++) begin
				set_geometry($urandom_range(6, 8), $urandom_range(0, 5),
					$urandom_range(0, 4), $urandom_range(0, 2), $urandom_range(0, 2),
					$urandom_range(6, 8), $urandom_range(3, 4), $urandom_range(0, 1));
				for (int i = 0; i < 9; i++) begin
					r = $urandom_range(0, 99);
					if (r < 20)
						send_command(CMD_LOAD, ($urandom_range(0, 7) == 0) ? 16'($urandom)
							: 16'($urandom_range(0, 255)), 16'($urandom), 8'($urandom),
							12'($urandom), 12'($urandom), 1'($urandom));
					else if (r < 35)
						send_command(CMD_WRITE, ($urandom_range(0, 3) == 0) ? 16'($urandom)
							: 16'($urandom_range(0, 255)), 16'($urandom), 8'($urandom),
							12'($urandom), 12'($urandom), 1'($urandom));
					else if (r < 50)
						send_command(CMD_READ, 16'(fb_written_list[$urandom_range(0,
							fb_written_list.size() - 1)]), 16'($urandom), 8'($urandom),
							12'($urandom), 12'($urandom), 1'($urandom));
					else if (r < 60)
						safe_blit($signed(12'($urandom)), $signed(12'($urandom)),
							1'($urandom));
					else
						safe_blit($urandom_range(0, 14) - 6, $urandom_range(0, 10) - 5,
							1'($urandom));
					// hold off until everything is back
					if (i == 5) drain();
				end
			end
		end
	endtask

	// Receiver: alternate stretches of full rate and random stalls.
	int stall_span = 0;
	bit stall_mode = 1'b0;
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_span <= $urandom_range(5, 60);
			stall_mode <= $urandom_range(0, 1);
		end else begin
			stall_span <= stall_span - 1;
		end
		m_axis_tready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
	end

	always @(posedge clk) begin
		blit_result_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[33:0];
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected: %h", m_axis_tdata);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (got.read_data !== want.read_data) begin
					$error("read_data: expected %h, got %h", want.read_data, got.read_data);
					errors++;
				end
				if (got.pixels_written !== want.pixels_written) begin
					$error("pixels_written: expected %0d, got %0d", want.pixels_written,
						got.pixels_written);
					errors++;
				end
				if (got.off_screen !== want.off_screen) begin
					$error("off_screen: expected %b, got %b", want.off_screen,
						got.off_screen);
					errors++;
				end
				n_pixels += got.pixels_written;
				if (got.off_screen === 1'b1) n_rejects++;
			end
		end
	end

	always @(posedge clk) begin
		if (in_reset_window || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WatchdogLimit) begin
			$display("watchdog: no beat for %0d cycles", WatchdogLimit);
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		tex_stride = 64; crop_width = 16; crop_height = 16; src_off_x = 0; src_off_y = 0;
		fb_width = 128; fb_height = 128; blend_mode = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		in_reset_window = 1'b0;
		test_access_at_reset();
		test_fill_stores();
		test_opaque_clipping();
		test_blend_threshold();
		test_register_extremes();
		test_random_mix();
		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d commands: %0d blits (%0d rejected off screen), %0d reads,",
			n_beats, n_blits, n_rejects, n_reads);
		$display("%0d framebuffer pixels drawn across opaque and blend geometries", n_pixels);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
